>>> sv/cseu_pkg.sv
// shared types, opcodes and constants for the instruction-subset execute unit
`default_nettype none

package cseu_pkg;

   localparam int unsigned XLEN      = 32;
   localparam int unsigned REG_IDX_W = 4;
   localparam int unsigned REG_COUNT = 16;

   // stream word widths, payload rounded up to whole bytes
   localparam int unsigned REQ_DATA_W = 64;
   localparam int unsigned RSP_DATA_W = 72;

   typedef logic [XLEN-1:0]      word_type;
   typedef logic [REG_IDX_W-1:0] ridx_type;

   // low opcode byte of the instruction word
   localparam logic [7:0] OP_MOVHA   = 8'h91;
   localparam logic [7:0] OP_MOV     = 8'h3B;
   localparam logic [7:0] OP_LEA     = 8'hD9;
   localparam logic [7:0] OP_JI      = 8'hDC;
   localparam logic [7:0] OP_MTCR    = 8'hCD;
   localparam logic [7:0] OP_ISYNC   = 8'h0D;
   localparam logic [7:0] OP_LDW_SLR = 8'h54;
   localparam logic [7:0] OP_LDW_BOL = 8'h19;
   localparam logic [7:0] OP_ADDC    = 8'hC2;
   localparam logic [7:0] OP_MOVH    = 8'h7B;
   localparam logic [7:0] OP_AND     = 8'h26;
   localparam logic [7:0] OP_JNE     = 8'hDF;
   localparam logic [7:0] OP_SUBA    = 8'h01;
   localparam logic [7:0] OP_MOVD    = 8'h80;

   // core register offsets reachable by mtcr
   localparam logic [15:0] CR_PCXI   = 16'hFE00;
   localparam logic [15:0] CR_PSW    = 16'hFE04;
   localparam logic [15:0] CR_PC     = 16'hFE08;
   localparam logic [15:0] CR_SYSCON = 16'hFE14;

   // request kinds carried in tuser
   localparam logic CMD_EXEC = 1'b0;
   localparam logic CMD_LOAD = 1'b1;

   localparam word_type ENTRY_PC_RESET = 32'hA000_0000;

   typedef enum logic [1:0] {
      ERR_NONE      = 2'd0,
      ERR_OPCODE    = 2'd1,
      ERR_CR_OFFSET = 2'd2,
      ERR_LOAD_DATA = 2'd3
   } err_type;

   // one register file write
   typedef struct packed {
      logic     en;
      ridx_type idx;
      word_type data;
   } wr_type;

   // architectural state held in flops
   typedef struct packed {
      word_type pc;
      logic     load_pending;
      ridx_type load_dest;
      logic     stopped;
   } arch_type;

   // everything one executed word changes or reports
   typedef struct packed {
      wr_type   dwr;
      wr_type   awr;
      logic     pcxi_we;
      logic     psw_we;
      logic     syscon_we;
      word_type cr_data;
      arch_type arch_next;
      logic     read_request;
      word_type read_address;
      err_type  error_code;
   } exec_type;

endpackage

`default_nettype wire

>>> sv/cseu_regfile.sv
// 16 x 32 register file: sync-read memory, valid bits and write forwarding
`default_nettype none

module cseu_regfile (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               rd_en,
   input  wire cseu_pkg::ridx_type rd_idx_a,
   input  wire cseu_pkg::ridx_type rd_idx_b,
   input  wire cseu_pkg::wr_type   wr,
   output cseu_pkg::word_type      rd_data_a,
   output cseu_pkg::word_type      rd_data_b
);

   cseu_pkg::word_type mem_ff [cseu_pkg::REG_COUNT];
   cseu_pkg::word_type rd_a_ff;
   cseu_pkg::word_type rd_b_ff;
   cseu_pkg::ridx_type idx_a_ff;
   cseu_pkg::ridx_type idx_b_ff;
   cseu_pkg::wr_type   fwd_ff;
   logic [cseu_pkg::REG_COUNT-1:0] vld_ff;
   logic [cseu_pkg::REG_COUNT-1:0] vld_in;

   // memory array, read returns the old contents on a same-edge write
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_a_ff <= mem_ff[rd_idx_a];
         rd_b_ff <= mem_ff[rd_idx_b];
      end
      if (wr.en) begin
         mem_ff[wr.idx] <= wr.data;
      end
   end

   // capture read indexes and the write landing on the read edge
   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_ff   <= '0;
         idx_a_ff <= '0;
         idx_b_ff <= '0;
      end else if (rd_en) begin
         fwd_ff   <= wr;
         idx_a_ff <= rd_idx_a;
         idx_b_ff <= rd_idx_b;
      end
   end

   // per-entry valid, an entry never written reads as zero
   always_comb begin
      vld_in = vld_ff;
      if (wr.en) begin
         vld_in[wr.idx] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // resolve read data: forwarded write, then memory, then reset value
   always_comb begin
      if (fwd_ff.en && fwd_ff.idx == idx_a_ff) begin
         rd_data_a = fwd_ff.data;
      end else if (vld_ff[idx_a_ff]) begin
         rd_data_a = rd_a_ff;
      end else begin
         rd_data_a = '0;
      end
      if (fwd_ff.en && fwd_ff.idx == idx_b_ff) begin
         rd_data_b = fwd_ff.data;
      end else if (vld_ff[idx_b_ff]) begin
         rd_data_b = rd_b_ff;
      end else begin
         rd_data_b = '0;
      end
   end

endmodule

`default_nettype wire

>>> sv/cseu_exec.sv
// decode and execute of one word against operands and architectural state
`default_nettype none

module cseu_exec (
   input  wire logic               cmd,
   input  wire cseu_pkg::word_type insn,
   input  wire cseu_pkg::word_type load_data,
   input  wire cseu_pkg::arch_type arch,
   input  wire cseu_pkg::word_type d_a,
   input  wire cseu_pkg::word_type d_b,
   input  wire cseu_pkg::word_type a_a,
   input  wire cseu_pkg::word_type a_b,
   output cseu_pkg::exec_type      exe
);

   localparam int unsigned XLEN = cseu_pkg::XLEN;

   cseu_pkg::ridx_type idx_a;
   cseu_pkg::ridx_type idx_b;
   cseu_pkg::ridx_type idx_c;
   logic [15:0]        k16;
   cseu_pkg::word_type off16;
   cseu_pkg::word_type const4;
   cseu_pkg::word_type disp15;
   cseu_pkg::word_type pc2;
   cseu_pkg::word_type pc4;

   // operand fields
   assign idx_a  = insn[11:8];
   assign idx_b  = insn[15:12];
   assign idx_c  = insn[31:28];
   assign k16    = insn[27:12];
   assign off16  = {{(XLEN-16){insn[27]}}, insn[27:22], insn[31:28], insn[21:16]};
   assign const4 = {{(XLEN-4){insn[15]}}, insn[15:12]};
   assign disp15 = {{(XLEN-16){insn[30]}}, insn[30:16], 1'b0};
   assign pc2    = arch.pc + XLEN'(2);
   assign pc4    = arch.pc + XLEN'(4);

   always_comb begin
      exe           = '0;
      exe.arch_next = arch;
      exe.cr_data   = d_a;
      exe.error_code = cseu_pkg::ERR_NONE;

      if (!arch.stopped) begin
         if (cmd == cseu_pkg::CMD_LOAD) begin
            // completion of a pending load
            if (arch.load_pending) begin
               exe.dwr                    = '{en: 1'b1, idx: arch.load_dest, data: load_data};
               exe.arch_next.load_pending = 1'b0;
            end else begin
               exe.error_code = cseu_pkg::ERR_LOAD_DATA;
            end
         end else begin
            // any executed word abandons a pending load
            exe.arch_next.load_pending = 1'b0;
            unique case (insn[7:0])
               cseu_pkg::OP_MOVHA: begin
                  exe.awr = '{en: 1'b1, idx: idx_c, data: {k16, {(XLEN-16){1'b0}}}};
                  exe.arch_next.pc = pc4;
               end
               cseu_pkg::OP_MOV: begin
                  exe.dwr = '{en: 1'b1, idx: idx_c, data: {{(XLEN-16){k16[15]}}, k16}};
                  exe.arch_next.pc = pc4;
               end
               cseu_pkg::OP_LEA: begin
                  exe.awr = '{en: 1'b1, idx: idx_a, data: a_b + off16};
                  exe.arch_next.pc = pc4;
               end
               cseu_pkg::OP_JI: begin
                  exe.arch_next.pc = {a_a[XLEN-1:1], 1'b0};
               end
               cseu_pkg::OP_MTCR: begin
                  unique case (k16)
                     cseu_pkg::CR_PCXI: begin
                        exe.pcxi_we      = 1'b1;
                        exe.arch_next.pc = pc4;
                     end
                     cseu_pkg::CR_PSW: begin
                        exe.psw_we       = 1'b1;
                        exe.arch_next.pc = pc4;
                     end
                     cseu_pkg::CR_PC: begin
                        exe.arch_next.pc = d_a + XLEN'(4);
                     end
                     cseu_pkg::CR_SYSCON: begin
                        exe.syscon_we    = 1'b1;
                        exe.arch_next.pc = pc4;
                     end
                     default: begin
                        exe.error_code = cseu_pkg::ERR_CR_OFFSET;
                     end
                  endcase
               end
               cseu_pkg::OP_ISYNC: begin
                  exe.arch_next.pc = pc4;
               end
               cseu_pkg::OP_LDW_SLR: begin
                  exe.read_request           = 1'b1;
                  exe.read_address           = a_b;
                  exe.arch_next.load_pending = 1'b1;
                  exe.arch_next.load_dest    = idx_a;
                  exe.arch_next.pc           = pc2;
               end
               cseu_pkg::OP_LDW_BOL: begin
                  exe.read_request           = 1'b1;
                  exe.read_address           = a_b + off16;
                  exe.arch_next.load_pending = 1'b1;
                  exe.arch_next.load_dest    = idx_a;
                  exe.arch_next.pc           = pc4;
               end
               cseu_pkg::OP_ADDC: begin
                  exe.dwr = '{en: 1'b1, idx: idx_a, data: d_a + const4};
                  exe.arch_next.pc = pc2;
               end
               cseu_pkg::OP_MOVH: begin
                  exe.dwr = '{en: 1'b1, idx: idx_c, data: {k16, {(XLEN-16){1'b0}}}};
                  exe.arch_next.pc = pc4;
               end
               cseu_pkg::OP_AND: begin
                  exe.dwr = '{en: 1'b1, idx: idx_a, data: d_a & d_b};
                  exe.arch_next.pc = pc2;
               end
               cseu_pkg::OP_JNE: begin
                  if (d_a != const4) begin
                     exe.arch_next.pc = arch.pc + disp15;
                  end else begin
                     exe.arch_next.pc = pc4;
                  end
               end
               cseu_pkg::OP_SUBA: begin
                  exe.awr = '{en: 1'b1, idx: idx_c, data: a_a - a_b};
                  exe.arch_next.pc = pc4;
               end
               cseu_pkg::OP_MOVD: begin
                  exe.dwr = '{en: 1'b1, idx: idx_a, data: a_b};
                  exe.arch_next.pc = pc2;
               end
               default: begin
                  exe.error_code = cseu_pkg::ERR_OPCODE;
               end
            endcase
         end
         // any error stops the core for good
         if (exe.error_code != cseu_pkg::ERR_NONE) begin
            exe.arch_next.stopped = 1'b1;
         end
      end
   end

endmodule

`default_nettype wire

>>> sv/cpu_subset_instruction_execute_unit.sv
// top level: stream ports, execute stage, architectural flops and result register
// a word accepted passes through the execute stage registers, then the result register
// throughput: one word per cycle unless the result side stalls; the register files are
//    read at the accept edge, with the write of the preceding word forwarded
// reset (synchronous, active high) clears pc to the entry point, core registers,
//    load and halt state and the register file valid bits; no clearing pass
`default_nettype none

module cpu_subset_instruction_execute_unit (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // configuration: entry program counter
   input  wire logic                              csr_wr_en,
   input  wire cseu_pkg::word_type                csr_wr_data,
   // request channel
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [cseu_pkg::REQ_DATA_W-1:0]   req_tdata,  // insn_word, load_data
   input  wire logic                              req_tuser,  // cmd
   // result channel
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // fetch_pc, read_request, read_address, error_code, halted, zero pad
   output logic [cseu_pkg::RSP_DATA_W-1:0]        rsp_tdata
);

   localparam int unsigned XLEN = cseu_pkg::XLEN;

   logic req_fire;
   logic s1_fire;

   // execute stage payload
   logic               s1_valid_ff;
   logic               s1_valid_in;
   logic               s1_cmd_ff;
   cseu_pkg::word_type s1_insn_ff;
   cseu_pkg::word_type s1_load_data_ff;

   // architectural state outside the register files
   cseu_pkg::arch_type arch_ff;
   cseu_pkg::arch_type arch_in;
   cseu_pkg::word_type pcxi_ff;
   cseu_pkg::word_type psw_ff;
   cseu_pkg::word_type syscon_ff;
   cseu_pkg::word_type entry_pc_ff;
   cseu_pkg::word_type entry_pc_in;

   // result register
   logic                            out_valid_ff;
   logic                            out_valid_in;
   logic [cseu_pkg::RSP_DATA_W-1:0] out_data_ff;

   cseu_pkg::word_type d_a;
   cseu_pkg::word_type d_b;
   cseu_pkg::word_type a_a;
   cseu_pkg::word_type a_b;
   cseu_pkg::exec_type exe;
   cseu_pkg::wr_type   dwr;
   cseu_pkg::wr_type   awr;

   // handshake
   assign s1_fire    = s1_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_fire;
   assign req_fire   = req_tvalid && req_tready;

   // register file operand reads issued on accept
   cseu_regfile u_dregs (
      .clock     (clock),
      .reset     (reset),
      .rd_en     (req_fire),
      .rd_idx_a  (req_tdata[11:8]),
      .rd_idx_b  (req_tdata[15:12]),
      .wr        (dwr),
      .rd_data_a (d_a),
      .rd_data_b (d_b)
   );

   cseu_regfile u_aregs (
      .clock     (clock),
      .reset     (reset),
      .rd_en     (req_fire),
      .rd_idx_a  (req_tdata[11:8]),
      .rd_idx_b  (req_tdata[15:12]),
      .wr        (awr),
      .rd_data_a (a_a),
      .rd_data_b (a_b)
   );

   // execute stage
   cseu_exec u_exec (
      .cmd       (s1_cmd_ff),
      .insn      (s1_insn_ff),
      .load_data (s1_load_data_ff),
      .arch      (arch_ff),
      .d_a       (d_a),
      .d_b       (d_b),
      .a_a       (a_a),
      .a_b       (a_b),
      .exe       (exe)
   );

   // writes land only when the word leaves the execute stage
   always_comb begin
      dwr    = exe.dwr;
      dwr.en = exe.dwr.en && s1_fire;
      awr    = exe.awr;
      awr.en = exe.awr.en && s1_fire;
   end

   // execute stage valid and payload
   assign s1_valid_in = req_fire ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_cmd_ff       <= req_tuser;
         s1_insn_ff      <= req_tdata[XLEN-1:0];
         s1_load_data_ff <= req_tdata[2*XLEN-1:XLEN];
      end
   end

   // entry point returns to its default on reset and seeds pc
   assign entry_pc_in = reset ? cseu_pkg::ENTRY_PC_RESET
                              : (csr_wr_en ? csr_wr_data : entry_pc_ff);

   always_ff @(posedge clock) begin
      entry_pc_ff <= entry_pc_in;
   end

   // architectural state update
   assign arch_in = s1_fire ? exe.arch_next : arch_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         arch_ff   <= '{pc: entry_pc_in, load_pending: 1'b0, load_dest: '0, stopped: 1'b0};
         pcxi_ff   <= '0;
         psw_ff    <= '0;
         syscon_ff <= '0;
      end else begin
         arch_ff <= arch_in;
         if (s1_fire && exe.pcxi_we) begin
            pcxi_ff <= exe.cr_data;
         end
         if (s1_fire && exe.psw_we) begin
            psw_ff <= exe.cr_data;
         end
         if (s1_fire && exe.syscon_we) begin
            syscon_ff <= exe.cr_data;
         end
      end
   end

   // result register
   assign out_valid_in = s1_fire ? 1'b1 : (rsp_tready ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire) begin
         out_data_ff <= {
            (cseu_pkg::RSP_DATA_W - 2*XLEN - 4)'(0),
            exe.arch_next.stopped,
            exe.error_code,
            exe.read_address,
            exe.read_request,
            exe.arch_next.pc
         };
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

endmodule

`default_nettype wire

>>> sv/cseu_checker.sv
// port-level checks on the execute unit, bound to the top level
`default_nettype none

module cseu_checker (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            req_tvalid,
   input wire logic                            req_tready,
   input wire logic                            rsp_tvalid,
   input wire logic                            rsp_tready,
   input wire logic [cseu_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   // a stalled result word holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result word changed while stalled");

   // once halted, every later result word reports halted
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[67] |=> !rsp_tvalid || rsp_tdata[67])
      else $error("halt state cleared without reset");

   // an error always comes with halt and without a read request
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[66:65] != cseu_pkg::ERR_NONE
         |-> rsp_tdata[67] && !rsp_tdata[32])
      else $error("error reported without halt or with a read request");

   // no read request means a zero read address
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[32] |-> rsp_tdata[64:33] == 32'd0)
      else $error("read address set without a read request");

   // the request side stalls only behind a held result word
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("request stalled with the result side free");

endmodule

bind cpu_subset_instruction_execute_unit cseu_checker u_cseu_checker (.*);

`default_nettype wire

>>> dv/cpu_subset_instruction_execute_unit_tb.sv
// self-checking testbench for the instruction-subset execute unit
module cpu_subset_instruction_execute_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   // one result word as it sits in rsp_tdata, fetch_pc in the lowest bits
   typedef struct packed {
      logic               halted;
      cseu_pkg::err_type  err;
      cseu_pkg::word_type raddr;
      logic               rreq;
      cseu_pkg::word_type pc;
   } rsp_word_type;

   localparam int RSP_FIELDS_W = $bits(rsp_word_type);

   // one directed row; typed rows carry their expected result word
   typedef struct {
      logic               cmd;
      cseu_pkg::word_type insn;
      cseu_pkg::word_type ld;
      logic               typed;
      rsp_word_type       want;
   } dir_row_type;

   logic clock;
   logic reset = 1'b1;
   logic csr_wr_en = 1'b0;
   cseu_pkg::word_type csr_wr_data = '0;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [cseu_pkg::REQ_DATA_W-1:0] req_tdata = '0;
   logic req_tuser = cseu_pkg::CMD_EXEC;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [cseu_pkg::RSP_DATA_W-1:0] rsp_tdata;

   cpu_subset_instruction_execute_unit DUT (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

   // predicted architectural state, as left by reset
   cseu_pkg::word_type gpr_d [16] = '{default: '0};
   cseu_pkg::word_type gpr_a [16] = '{default: '0};
   cseu_pkg::word_type pc_m       = cseu_pkg::ENTRY_PC_RESET;
   cseu_pkg::word_type pcxi_m     = '0;
   cseu_pkg::word_type psw_m      = '0;
   cseu_pkg::word_type syscon_m   = '0;
   logic               ld_busy    = 1'b0;
   cseu_pkg::ridx_type ld_reg     = '0;
   logic               stop_m     = 1'b0;
   cseu_pkg::word_type entry_pc_m = cseu_pkg::ENTRY_PC_RESET;

   logic [7:0] op_list [14] = '{cseu_pkg::OP_MOVHA, cseu_pkg::OP_MOV, cseu_pkg::OP_LEA,
      cseu_pkg::OP_JI, cseu_pkg::OP_MTCR, cseu_pkg::OP_ISYNC, cseu_pkg::OP_LDW_SLR,
      cseu_pkg::OP_LDW_BOL, cseu_pkg::OP_ADDC, cseu_pkg::OP_MOVH, cseu_pkg::OP_AND,
      cseu_pkg::OP_JNE, cseu_pkg::OP_SUBA, cseu_pkg::OP_MOVD};
   logic [15:0] cr_list [4] = '{cseu_pkg::CR_PCXI, cseu_pkg::CR_PSW, cseu_pkg::CR_PC,
      cseu_pkg::CR_SYSCON};

   rsp_word_type retire_q [$];
   dir_row_type  dir_rows [$];
   int           err_count = 0;
   int           burst_left = 0;
   bit           hold_rsp = 1'b0;

   // clock
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // watchdog
   initial begin
      #5_000_000;
      $display("cpu_subset_instruction_execute_unit_tb: errors");
      $finish;
   end

   task automatic flag(input string what, input logic [31:0] got, input logic [31:0] want);
      $display("mismatch %s: got %h want %h", what, got, want);
      err_count++;
   endtask

   // instruction encoders for the directed rows
   function automatic cseu_pkg::word_type enc_ab(input logic [7:0] op,
                                                 input cseu_pkg::ridx_type a,
                                                 input cseu_pkg::ridx_type b);
      return {16'h0, b, a, op};
   endfunction

   function automatic cseu_pkg::word_type enc_k16(input logic [7:0] op,
                                                  input cseu_pkg::ridx_type c,
                                                  input logic [15:0] k16);
      return {c, k16, 4'h0, op};
   endfunction

   function automatic cseu_pkg::word_type enc_bol(input logic [7:0] op,
                                                  input cseu_pkg::ridx_type a,
                                                  input cseu_pkg::ridx_type b,
                                                  input logic [15:0] off);
      return {off[9:6], off[15:10], off[5:0], b, a, op};
   endfunction

   function automatic cseu_pkg::word_type enc_jne(input cseu_pkg::ridx_type a,
                                                  input logic [3:0] c4,
                                                  input logic [14:0] disp);
      return {1'b0, disp, c4, a, cseu_pkg::OP_JNE};
   endfunction

   function automatic cseu_pkg::word_type enc_mtcr(input cseu_pkg::ridx_type a,
                                                   input logic [15:0] cr);
      return {4'h0, cr, a, cseu_pkg::OP_MTCR};
   endfunction

   // executes one word against the predicted state and returns its result word
   task automatic execute_word(input logic cmd, input cseu_pkg::word_type w,
                               input cseu_pkg::word_type ld, output rsp_word_type r);
      cseu_pkg::ridx_type ra, rb, rc;
      logic [15:0]        k16;
      cseu_pkg::word_type off16, c4;
      cseu_pkg::err_type  e;
      logic               req;
      cseu_pkg::word_type raddr;
      e = cseu_pkg::ERR_NONE;
      req = 1'b0;
      raddr = '0;
      if (!stop_m) begin
         if (cmd == cseu_pkg::CMD_LOAD) begin
            if (ld_busy) begin
               gpr_d[ld_reg] = ld;
               ld_busy = 1'b0;
            end else begin
               e = cseu_pkg::ERR_LOAD_DATA;
            end
         end else begin
            ra = w[11:8];
            rb = w[15:12];
            rc = w[31:28];
            k16 = w[27:12];
            off16 = {{16{w[27]}}, w[27:22], w[31:28], w[21:16]};
            c4 = {{28{rb[3]}}, rb};
            // a new instruction drops any load still waiting for data
            ld_busy = 1'b0;
            case (w[7:0])
               cseu_pkg::OP_MOVHA: begin
                  gpr_a[rc] = {k16, 16'h0};
                  pc_m += 4;
               end
               cseu_pkg::OP_MOV: begin
                  gpr_d[rc] = {{16{k16[15]}}, k16};
                  pc_m += 4;
               end
               cseu_pkg::OP_LEA: begin
                  gpr_a[ra] = gpr_a[rb] + off16;
                  pc_m += 4;
               end
               cseu_pkg::OP_JI: begin
                  pc_m = {gpr_a[ra][31:1], 1'b0};
               end
               cseu_pkg::OP_MTCR: begin
                  case (k16)
                     cseu_pkg::CR_PCXI:   pcxi_m = gpr_d[ra];
                     cseu_pkg::CR_PSW:    psw_m = gpr_d[ra];
                     cseu_pkg::CR_PC:     pc_m = gpr_d[ra];
                     cseu_pkg::CR_SYSCON: syscon_m = gpr_d[ra];
                     default:             e = cseu_pkg::ERR_CR_OFFSET;
                  endcase
                  if (e == cseu_pkg::ERR_NONE) pc_m += 4;
               end
               cseu_pkg::OP_ISYNC: begin
                  pc_m += 4;
               end
               cseu_pkg::OP_LDW_SLR: begin
                  req = 1'b1;
                  raddr = gpr_a[rb];
                  ld_busy = 1'b1;
                  ld_reg = ra;
                  pc_m += 2;
               end
               cseu_pkg::OP_LDW_BOL: begin
                  req = 1'b1;
                  raddr = gpr_a[rb] + off16;
                  ld_busy = 1'b1;
                  ld_reg = ra;
                  pc_m += 4;
               end
               cseu_pkg::OP_ADDC: begin
                  gpr_d[ra] += c4;
                  pc_m += 2;
               end
               cseu_pkg::OP_MOVH: begin
                  gpr_d[rc] = {k16, 16'h0};
                  pc_m += 4;
               end
               cseu_pkg::OP_AND: begin
                  gpr_d[ra] &= gpr_d[rb];
                  pc_m += 2;
               end
               cseu_pkg::OP_JNE: begin
                  if (gpr_d[ra] != c4) pc_m += {{16{w[30]}}, w[30:16], 1'b0};
                  else pc_m += 4;
               end
               cseu_pkg::OP_SUBA: begin
                  gpr_a[rc] = gpr_a[ra] - gpr_a[rb];
                  pc_m += 4;
               end
               cseu_pkg::OP_MOVD: begin
                  gpr_d[ra] = gpr_a[rb];
                  pc_m += 2;
               end
               default: e = cseu_pkg::ERR_OPCODE;
            endcase
         end
         if (e != cseu_pkg::ERR_NONE) stop_m = 1'b1;
      end
      r.pc = pc_m;
      r.rreq = req;
      r.raddr = raddr;
      r.err = e;
      r.halted = stop_m;
   endtask

   // offers one word in bursts with random gaps, returns at the negedge after accept
   task automatic send_word(input logic cmd, input cseu_pkg::word_type w,
                            input cseu_pkg::word_type ld);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata <= {ld, w};
      req_tuser <= cmd;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   // predicts, queues the expected result word and sends the request word
   task automatic issue(input logic cmd, input cseu_pkg::word_type w,
                        input cseu_pkg::word_type ld,
                        input logic typed = 1'b0, input rsp_word_type want = '0);
      rsp_word_type p;
      execute_word(cmd, w, ld, p);
      retire_q = {retire_q, (typed ? want : p)};
      send_word(cmd, w, ld);
   endtask

   // stops offering and waits for every expected result word
   task automatic drain();
      int n;
      req_tvalid <= 1'b0;
      burst_left = 0;
      n = 0;
      while (retire_q.size() != 0 && n < 20000) begin
         @(negedge clock);
         n++;
      end
      if (retire_q.size() != 0) begin
         flag("result words never arrived", retire_q.size(), 0);
         retire_q.delete();
      end
      repeat (2) @(negedge clock);
   endtask

   task automatic set_entry_pc(input cseu_pkg::word_type v);
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      entry_pc_m = v;
   endtask

   task automatic add_row(input logic cmd, input cseu_pkg::word_type w,
                          input cseu_pkg::word_type ld);
      dir_row_type row;
      row.cmd = cmd;
      row.insn = w;
      row.ld = ld;
      row.typed = 1'b0;
      row.want = '0;
      dir_rows = {dir_rows, row};
   endtask

   task automatic add_row_typed(input logic cmd, input cseu_pkg::word_type w,
                                input cseu_pkg::word_type ld, input cseu_pkg::word_type pc,
                                input logic req, input cseu_pkg::word_type addr);
      dir_row_type row;
      row.cmd = cmd;
      row.insn = w;
      row.ld = ld;
      row.typed = 1'b1;
      row.want = '0;
      row.want.pc = pc;
      row.want.rreq = req;
      row.want.raddr = addr;
      row.want.err = cseu_pkg::ERR_NONE;
      row.want.halted = 1'b0;
      dir_rows = {dir_rows, row};
   endtask

   // random word, always a valid instruction, with a load mostly answered when one is waiting
   task automatic pick_random_word(output logic cmd, output cseu_pkg::word_type w,
                                   output cseu_pkg::word_type ld);
      int sel;
      logic [7:0] op;
      cmd = cseu_pkg::CMD_EXEC;
      w = $urandom;
      ld = $urandom;
      if (ld_busy && $urandom_range(0, 99) < 85) begin
         cmd = cseu_pkg::CMD_LOAD;
      end else begin
         sel = $urandom_range(0, 99);
         if (sel < 12) op = cseu_pkg::OP_LDW_SLR;
         else if (sel < 24) op = cseu_pkg::OP_LDW_BOL;
         else op = op_list[$urandom_range(0, 13)];
         w[7:0] = op;
         if (op == cseu_pkg::OP_MTCR) w[27:12] = cr_list[$urandom_range(0, 3)];
      end
   endtask

   // result checker
   always @(posedge clock) begin
      rsp_word_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[RSP_FIELDS_W-1:0];
         if (retire_q.size() == 0) begin
            flag("result word with nothing expected", got.pc, 0);
         end else begin
            want = retire_q.pop_front();
            if (got.pc !== want.pc) flag("fetch_pc", got.pc, want.pc);
            if (got.rreq !== want.rreq) flag("read_request", got.rreq, want.rreq);
            if (got.raddr !== want.raddr) flag("read_address", got.raddr, want.raddr);
            if (got.err !== want.err) flag("error_code", got.err, want.err);
            if (got.halted !== want.halted) flag("halted", got.halted, want.halted);
         end
      end
   end

   // receiver: stall pattern in randomly chosen modes, plus one long hold
   initial begin
      int mode;
      int left;
      mode = 0;
      left = 0;
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            rsp_tready <= 1'b0;
            repeat (300) @(negedge clock);
            hold_rsp = 1'b0;
         end
         if (left == 0) begin
            mode = $urandom_range(0, 3);
            left = 64;
         end
         left--;
         case (mode)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= 1'($urandom_range(0, 1));
            2: rsp_tready <= ($urandom_range(0, 3) == 0);
            default: rsp_tready <= ~rsp_tready;
         endcase
      end
   end

   // stimulus
   initial begin
      logic               cmd;
      cseu_pkg::word_type w, ld;
      cseu_pkg::err_type  kind;
      bit                 known;

      // directed rows: after reset, field extremes, every opcode, abandoned load
      add_row_typed(cseu_pkg::CMD_EXEC, enc_ab(cseu_pkg::OP_ISYNC, 0, 0), 32'h0,
                    32'hA000_0004, 1'b0, 32'h0);
      add_row_typed(cseu_pkg::CMD_EXEC, enc_k16(cseu_pkg::OP_MOV, 1, 16'h8000), 32'h0,
                    32'hA000_0008, 1'b0, 32'h0);
      add_row_typed(cseu_pkg::CMD_EXEC, enc_k16(cseu_pkg::OP_MOV, 15, 16'h7FFF), 32'h0,
                    32'hA000_000C, 1'b0, 32'h0);
      add_row_typed(cseu_pkg::CMD_EXEC, enc_k16(cseu_pkg::OP_MOVH, 2, 16'hFFFF), 32'h0,
                    32'hA000_0010, 1'b0, 32'h0);
      add_row_typed(cseu_pkg::CMD_EXEC, enc_k16(cseu_pkg::OP_MOVHA, 3, 16'h1234), 32'h0,
                    32'hA000_0014, 1'b0, 32'h0);
      add_row_typed(cseu_pkg::CMD_EXEC, enc_ab(cseu_pkg::OP_LDW_SLR, 4, 3), 32'h0,
                    32'hA000_0016, 1'b1, 32'h1234_0000);
      add_row_typed(cseu_pkg::CMD_LOAD, 32'h0, 32'hDEAD_BEEF,
                    32'hA000_0016, 1'b0, 32'h0);
      add_row(cseu_pkg::CMD_EXEC, enc_bol(cseu_pkg::OP_LEA, 5, 3, 16'h8000), 32'h0);
      add_row(cseu_pkg::CMD_EXEC, enc_bol(cseu_pkg::OP_LDW_BOL, 6, 5, 16'h7FFF), 32'h0);
      add_row(cseu_pkg::CMD_LOAD, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      add_row(cseu_pkg::CMD_EXEC, enc_ab(cseu_pkg::OP_LDW_SLR, 7, 3), 32'h0);
      add_row(cseu_pkg::CMD_EXEC, enc_ab(cseu_pkg::OP_ISYNC, 0, 0), 32'hFFFF_FFFF);
      add_row(cseu_pkg::CMD_EXEC, enc_ab(cseu_pkg::OP_ADDC, 1, 4'h8), 32'h0);
      add_row(cseu_pkg::CMD_EXEC, enc_ab(cseu_pkg::OP_ADDC, 15, 4'h7), 32'h0);
      add_row(cseu_pkg::CMD_EXEC, enc_ab(cseu_pkg::OP_AND, 2, 15), 32'h0);
      add_row(cseu_pkg::CMD_EXEC, enc_ab(cseu_pkg::OP_MOVD, 8, 5), 32'h0);
      add_row(cseu_pkg::CMD_EXEC, {4'd9, 12'h0, 4'd5, 4'd3, cseu_pkg::OP_SUBA}, 32'h0);
      add_row(cseu_pkg::CMD_EXEC, enc_mtcr(4, cseu_pkg::CR_PCXI), 32'h0);
      add_row(cseu_pkg::CMD_EXEC, enc_mtcr(4, cseu_pkg::CR_PSW), 32'h0);
      add_row(cseu_pkg::CMD_EXEC, enc_mtcr(4, cseu_pkg::CR_SYSCON), 32'h0);
      add_row(cseu_pkg::CMD_EXEC, enc_mtcr(1, cseu_pkg::CR_PC), 32'h0);
      add_row(cseu_pkg::CMD_EXEC, enc_jne(0, 4'h0, 15'h7FFF), 32'h0);
      add_row(cseu_pkg::CMD_EXEC, enc_jne(1, 4'h0, 15'h4000), 32'h0);
      add_row(cseu_pkg::CMD_EXEC, enc_jne(2, 4'hF, 15'h3FFF), 32'h0);
      add_row(cseu_pkg::CMD_EXEC, enc_bol(cseu_pkg::OP_LEA, 10, 3, 16'h0001), 32'h0);
      add_row(cseu_pkg::CMD_EXEC, enc_ab(cseu_pkg::OP_JI, 10, 0), 32'h0);

      // reset
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      set_entry_pc(32'hFFFF_FFFF);

      foreach (dir_rows[i])
         issue(dir_rows[i].cmd, dir_rows[i].insn, dir_rows[i].ld,
               dir_rows[i].typed, dir_rows[i].want);
      drain();
      set_entry_pc(32'h0000_0000);

      // random programs, with one long receiver hold early on
      for (int i = 0; i < 940; i++) begin
         if (i == 100) hold_rsp = 1'b1;
         pick_random_word(cmd, w, ld);
         issue(cmd, w, ld);
      end
      drain();
      set_entry_pc($urandom);

      for (int i = 0; i < 940; i++) begin
         pick_random_word(cmd, w, ld);
         issue(cmd, w, ld);
      end
      drain();
      set_entry_pc(cseu_pkg::ENTRY_PC_RESET);

      // one halting error, then words that the halted block must ignore
      kind = cseu_pkg::err_type'($urandom_range(1, 3));
      case (kind)
         cseu_pkg::ERR_OPCODE: begin
            do begin
               w = $urandom;
               known = 1'b0;
               foreach (op_list[j]) if (w[7:0] == op_list[j]) known = 1'b1;
            end while (known);
            issue(cseu_pkg::CMD_EXEC, w, $urandom);
         end
         cseu_pkg::ERR_CR_OFFSET: begin
            w = $urandom;
            w[7:0] = cseu_pkg::OP_MTCR;
            while (w[27:12] inside {cseu_pkg::CR_PCXI, cseu_pkg::CR_PSW, cseu_pkg::CR_PC,
                                    cseu_pkg::CR_SYSCON})
               w[27:12] = 16'($urandom);
            issue(cseu_pkg::CMD_EXEC, w, $urandom);
         end
         default: begin
            issue(cseu_pkg::CMD_EXEC, enc_ab(cseu_pkg::OP_ISYNC, 0, 0), $urandom);
            issue(cseu_pkg::CMD_LOAD, $urandom, $urandom);
         end
      endcase
      repeat (6) begin
         w = $urandom;
         w[7:0] = op_list[$urandom_range(0, 13)];
         issue(1'($urandom_range(0, 1)), w, $urandom);
      end
      drain();
      repeat (4) @(posedge clock);

      if (err_count == 0) begin
         $display("cpu_subset_instruction_execute_unit_tb: clean");
      end else begin
         $display("cpu_subset_instruction_execute_unit_tb: errors");
      end
      $finish;
   end

endmodule
